### hw/rtl/rpi_pkg.sv
// Shared types, constants and color expansion tables for the RGB565 palette indexer.
// Depends on nothing; every file of the block imports it.
`timescale 1ns / 1ps

package rpi_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int LINE_SLOTS      = 64;

    localparam int PAL_W   = $clog2(PALETTE_ENTRIES);
    localparam int COUNT_W = PAL_W + 1;
    localparam int SLOT_W  = $clog2(LINE_SLOTS);
    localparam int DIST_W  = 18;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_SLOT  = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;

    localparam logic KIND_SLOT  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  slot;
        logic [15:0] color;
        logic [7:0]  source_code;
    } req_word_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  index;
        logic        new_entry;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLOT_CHK,
        ST_PIX_RD,
        ST_MATCH,
        ST_NEAR,
        ST_UPDATE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    function automatic logic [8*32-1:0] build_exp5();
        logic [8*32-1:0] t;
        t = '0;
        for (int i = 0; i < 32; i++)
        begin
            t[i*8 +: 8] = 8'((i * 255 + 15) / 31);
        end
        return t;
    endfunction

    function automatic logic [8*64-1:0] build_exp6();
        logic [8*64-1:0] t;
        t = '0;
        for (int i = 0; i < 64; i++)
        begin
            t[i*8 +: 8] = 8'((i * 255 + 31) / 63);
        end
        return t;
    endfunction

    localparam logic [8*32-1:0] EXP5_LUT = build_exp5();
    localparam logic [8*64-1:0] EXP6_LUT = build_exp6();

    function automatic logic [23:0] expand565(logic [15:0] c);
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        r8 = EXP5_LUT[{c[15:11], 3'b000} +: 8];
        g8 = EXP6_LUT[{c[10:5], 3'b000} +: 8];
        b8 = EXP5_LUT[{c[4:0], 3'b000} +: 8];
        return {r8, g8, b8};
    endfunction

endpackage

### hw/rtl/rgb565_palette_indexer_unit.sv
// Top level of the RGB565 palette indexer: slot/pixel sequencer, palette and slot memories.
// Depends on rpi_pkg for word types, sizes, states and the RGB565 expansion tables.
// Channel table:
//   channel  handshake            word        direction
//   req      req_valid/req_stall  req_word_t  into the block
//   rsp      rsp_valid/rsp_stall  rsp_word_t  out of the block
// A frame start leaves the sequencer idle; a pixel runs ST_PIX_RD, ST_FETCH and ST_EMIT,
// an unchanged slot ST_SLOT_CHK, ST_FETCH and ST_EMIT. A slot color search reads the entries
// in order, paced by the single palette read port. With a full palette a nearest-color pass
// then runs every entry through one distance unit (three 8x8 squares, then a sum and compare).
// Reset empties the palette and clears all slot valid marks; no memory clearing pass.
// req_stall is high while an item is in work; a stalled result holds the last state only.
`timescale 1ns / 1ps

module rgb565_palette_indexer_unit
    import rpi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    logic [15:0] entry_rgb565_mem [PALETTE_ENTRIES];
    logic [23:0] entry_rgb888_mem [PALETTE_ENTRIES];
    logic [15:0] slot_color_mem   [LINE_SLOTS];
    logic [PAL_W-1:0] slot_remap_mem [LINE_SLOTS];

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [LINE_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_word_reg, rsp_word_next;

    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [15:0]         color_reg, color_next;
    logic [23:0]         color_rgb_reg, color_rgb_next;
    logic [PAL_W-1:0]    idx_reg, idx_next;
    logic                added_reg, added_next;
    logic                kind_reg, kind_next;
    logic                zero_rgb_reg, zero_rgb_next;
    logic [COUNT_W-1:0]  scan_reg, scan_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [PAL_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                sq_valid_reg, sq_valid_next;
    logic [PAL_W-1:0]    sq_idx_reg, sq_idx_next;
    logic [15:0]         sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DIST_W-1:0]   best_err_reg, best_err_next;
    logic [PAL_W-1:0]    best_idx_reg, best_idx_next;

    logic [15:0]         rd565_reg;
    logic [23:0]         rd888_reg;
    logic [15:0]         slot_color_rd_reg;
    logic [PAL_W-1:0]    slot_remap_rd_reg;

    logic [PAL_W-1:0]    entry_rd_addr;
    logic                entry_we;
    logic [SLOT_W-1:0]   slot_rd_addr;
    logic                slot_we;

    logic                req_accept;
    logic [7:0]          dr_abs, dg_abs, db_abs;
    logic [DIST_W-1:0]   dist_sum;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_word   = rsp_word_reg;

    // distance unit
    always_comb
    begin
        dr_abs = (rd888_reg[23:16] >= color_rgb_reg[23:16]) ?
                 rd888_reg[23:16] - color_rgb_reg[23:16] : color_rgb_reg[23:16] - rd888_reg[23:16];
        dg_abs = (rd888_reg[15:8] >= color_rgb_reg[15:8]) ?
                 rd888_reg[15:8] - color_rgb_reg[15:8] : color_rgb_reg[15:8] - rd888_reg[15:8];
        db_abs = (rd888_reg[7:0] >= color_rgb_reg[7:0]) ?
                 rd888_reg[7:0] - color_rgb_reg[7:0] : color_rgb_reg[7:0] - rd888_reg[7:0];
        dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        slot_valid_next = slot_valid_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_word_next   = rsp_word_reg;
        slot_next       = slot_reg;
        color_next      = color_reg;
        color_rgb_next  = color_rgb_reg;
        idx_next        = idx_reg;
        added_next      = added_reg;
        kind_next       = kind_reg;
        zero_rgb_next   = zero_rgb_reg;
        scan_next       = scan_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        sq_valid_next   = 1'b0;
        sq_idx_next     = pend_idx_reg;
        best_err_next   = best_err_reg;
        best_idx_next   = best_idx_reg;
        entry_rd_addr   = idx_reg;
        entry_we        = 1'b0;
        slot_rd_addr    = slot_reg;
        slot_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_word.cmd == CMD_PIXEL)
                begin
                    slot_rd_addr = req_word.source_code[SLOT_W-1:0];
                end
                else
                begin
                    slot_rd_addr = req_word.slot[SLOT_W-1:0];
                end
                if (req_accept)
                begin
                    slot_next      = req_word.slot[SLOT_W-1:0];
                    color_next     = req_word.color;
                    color_rgb_next = expand565(req_word.color);
                    added_next     = 1'b0;
                    zero_rgb_next  = 1'b0;
                    unique case (req_word.cmd)
                        CMD_FRAME:
                        begin
                            count_next      = '0;
                            slot_valid_next = '0;
                        end
                        CMD_SLOT:
                        begin
                            kind_next = KIND_SLOT;
                            if ({1'b0, req_word.slot} < 7'(LINE_SLOTS))
                            begin
                                state_next = ST_SLOT_CHK;
                            end
                        end
                        CMD_PIXEL:
                        begin
                            kind_next = KIND_PIXEL;
                            if ({1'b0, req_word.source_code[5:0]} < 7'(LINE_SLOTS))
                            begin
                                state_next = ST_PIX_RD;
                            end
                            else
                            begin
                                idx_next      = '0;
                                zero_rgb_next = 1'b1;
                                state_next    = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SLOT_CHK:
            begin
                if (slot_valid_reg[slot_reg] && (slot_color_rd_reg == color_reg))
                begin
                    idx_next   = slot_remap_rd_reg;
                    state_next = ST_FETCH;
                end
                else
                begin
                    scan_next  = '0;
                    state_next = ST_MATCH;
                end
            end

            ST_PIX_RD:
            begin
                idx_next   = slot_remap_rd_reg;
                state_next = ST_FETCH;
            end

            ST_MATCH:
            begin
                entry_rd_addr = scan_reg[PAL_W-1:0];
                priority if (pend_valid_reg && (rd565_reg == color_reg))
                begin
                    idx_next   = pend_idx_reg;
                    state_next = ST_UPDATE;
                end
                else if (scan_reg < count_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_reg[PAL_W-1:0];
                    scan_next       = scan_reg + 1'b1;
                end
                else if (pend_valid_reg)
                begin
                    pend_valid_next = 1'b0;
                end
                else if (count_reg < COUNT_W'(PALETTE_ENTRIES))
                begin
                    entry_we   = 1'b1;
                    idx_next   = count_reg[PAL_W-1:0];
                    added_next = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    scan_next     = '0;
                    best_err_next = '1;
                    best_idx_next = '0;
                    state_next    = ST_NEAR;
                end
            end

            ST_NEAR:
            begin
                entry_rd_addr = scan_reg[PAL_W-1:0];
                sq_valid_next = pend_valid_reg;
                if (scan_reg < COUNT_W'(PALETTE_ENTRIES))
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_reg[PAL_W-1:0];
                    scan_next       = scan_reg + 1'b1;
                end
                if (sq_valid_reg && (dist_sum < best_err_reg))
                begin
                    best_err_next = dist_sum;
                    best_idx_next = sq_idx_reg;
                end
                if ((scan_reg >= COUNT_W'(PALETTE_ENTRIES)) && !pend_valid_reg && !sq_valid_reg)
                begin
                    idx_next   = best_idx_reg;
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                slot_we                   = 1'b1;
                slot_valid_next[slot_reg] = 1'b1;
                state_next                = ST_FETCH;
            end

            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_word_next.kind      = kind_reg;
                    rsp_word_next.index     = 8'(idx_reg);
                    rsp_word_next.new_entry = added_reg;
                    rsp_word_next.red       = zero_rgb_reg ? 8'd0 : rd888_reg[23:16];
                    rsp_word_next.green     = zero_rgb_reg ? 8'd0 : rd888_reg[15:8];
                    rsp_word_next.blue      = zero_rgb_reg ? 8'd0 : rd888_reg[7:0];
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            slot_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            slot_valid_reg <= slot_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            pend_valid_reg <= pend_valid_next;
            sq_valid_reg   <= sq_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg  <= rsp_word_next;
        slot_reg      <= slot_next;
        color_reg     <= color_next;
        color_rgb_reg <= color_rgb_next;
        idx_reg       <= idx_next;
        added_reg     <= added_next;
        kind_reg      <= kind_next;
        zero_rgb_reg  <= zero_rgb_next;
        scan_reg      <= scan_next;
        pend_idx_reg  <= pend_idx_next;
        sq_idx_reg    <= sq_idx_next;
        sq_r_reg      <= 16'(dr_abs) * 16'(dr_abs);
        sq_g_reg      <= 16'(dg_abs) * 16'(dg_abs);
        sq_b_reg      <= 16'(db_abs) * 16'(db_abs);
        best_err_reg  <= best_err_next;
        best_idx_reg  <= best_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_rgb565_mem[count_reg[PAL_W-1:0]] <= color_reg;
            entry_rgb888_mem[count_reg[PAL_W-1:0]] <= color_rgb_reg;
        end
        rd565_reg <= entry_rgb565_mem[entry_rd_addr];
        rd888_reg <= entry_rgb888_mem[entry_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_color_mem[slot_reg] <= color_reg;
            slot_remap_mem[slot_reg] <= idx_reg;
        end
        slot_color_rd_reg <= slot_color_mem[slot_rd_addr];
        slot_remap_rd_reg <= slot_remap_mem[slot_rd_addr];
    end

endmodule
